/* src/tcl_pkg.sv */
package tcl_pkg;

    // Default configuration of the lexer.
    localparam int PREFIX_CHARS_DEFAULT = 8;
    localparam int QUEUE_DEPTH_DEFAULT  = 4;

    // Width of the word constants below, large enough for the widest prefix.
    localparam int WORD_BITS = 64;

    // Result kinds as they appear on the output item.
    typedef enum logic [2:0] {
        KIND_RESERVED      = 3'd0,
        KIND_INTEGER       = 3'd1,
        KIND_OPERATOR      = 3'd2,
        KIND_VARIABLE      = 3'd3,
        KIND_FLOAT         = 3'd4,
        KIND_STMT_END      = 3'd5,
        KIND_ACCEPT        = 3'd6,
        KIND_COMPILE_ERROR = 3'd7
    } kind_t;

    // One queue entry holds the one or two results caused by an input item.
    typedef struct packed {
        logic  pair;
        kind_t first;
        kind_t second;
    } entry_t;

    // Character codes with a special meaning.
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // A fixed word, first character in the lowest byte, with its length.
    typedef struct packed {
        logic [WORD_BITS-1:0] text;
        logic [3:0]           len;
    } word_t;

    // Turns a string literal (first character highest) into byte order with
    // the first character in the lowest byte and zeros above the word.
    function automatic logic [WORD_BITS-1:0] word_le(logic [WORD_BITS-1:0] lit, int n);
        logic [WORD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS / 8; i++) begin
            if (i < n) begin
                r[8*i +: 8] = lit[8*(n-1-i) +: 8];
            end
        end
        return r;
    endfunction

    localparam word_t RESERVED_WORDS [16] = '{
        '{word_le("const", 5),   4'd5},
        '{word_le("int", 3),     4'd3},
        '{word_le("float", 5),   4'd5},
        '{word_le("double", 6),  4'd6},
        '{word_le("long", 4),    4'd4},
        '{word_le("static", 6),  4'd6},
        '{word_le("void", 4),    4'd4},
        '{word_le("char", 4),    4'd4},
        '{word_le("extern", 6),  4'd6},
        '{word_le("return", 6),  4'd6},
        '{word_le("break", 5),   4'd5},
        '{word_le("enum", 4),    4'd4},
        '{word_le("struct", 6),  4'd6},
        '{word_le("typedef", 7), 4'd7},
        '{word_le("union", 5),   4'd5},
        '{word_le("goto", 4),    4'd4}
    };

    localparam word_t OPERATOR_WORDS [11] = '{
        '{word_le("+", 1),  4'd1},
        '{word_le("-", 1),  4'd1},
        '{word_le("*", 1),  4'd1},
        '{word_le("/", 1),  4'd1},
        '{word_le("=", 1),  4'd1},
        '{word_le("==", 2), 4'd2},
        '{word_le("!=", 2), 4'd2},
        '{word_le(">=", 2), 4'd2},
        '{word_le("<=", 2), 4'd2},
        '{word_le(">", 1),  4'd1},
        '{word_le("<", 1),  4'd1}
    };

endpackage

/* src/tcl_front.sv */
module tcl_front #(
    parameter int PREFIX_CHARS = tcl_pkg::PREFIX_CHARS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       char_code,
    input  logic             end_of_input,
    output logic             push,
    output tcl_pkg::entry_t  push_entry
);

    localparam int PREFIX_BITS = 8 * PREFIX_CHARS;

    logic [PREFIX_BITS-1:0] prefix_reg, prefix_next;
    logic [7:0]             len_reg, len_next;
    logic                   all_digits_reg, all_digits_next;
    logic                   ident_ok_reg, ident_ok_next;
    logic [1:0]             dot_count_reg, dot_count_next;
    logic                   error_reg, error_next;
    logic                   ended_reg, ended_next;

    logic [tcl_pkg::WORD_BITS-1:0] prefix_wide;
    logic                          reserved_hit, operator_hit;
    logic                          tok_has, tok_bad;
    tcl_pkg::kind_t                tok_kind;
    logic                          is_digit, is_letter, is_space, is_semi, is_dot;
    logic                          err_after, ended_after;
    tcl_pkg::kind_t                final_kind;

    // Compare the pending token against the fixed word lists in parallel.
    always_comb begin
        prefix_wide  = tcl_pkg::WORD_BITS'(prefix_reg);
        reserved_hit = 1'b0;
        operator_hit = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if (len_reg == 8'(tcl_pkg::RESERVED_WORDS[i].len) &&
                prefix_wide == tcl_pkg::RESERVED_WORDS[i].text) begin
                reserved_hit = 1'b1;
            end
        end
        for (int i = 0; i < 11; i++) begin
            if (len_reg == 8'(tcl_pkg::OPERATOR_WORDS[i].len) &&
                prefix_wide == tcl_pkg::OPERATOR_WORDS[i].text) begin
                operator_hit = 1'b1;
            end
        end
    end

    // Class of the pending token, in priority order.
    always_comb begin
        tok_has  = (len_reg != 8'd0);
        tok_bad  = 1'b0;
        tok_kind = tcl_pkg::KIND_RESERVED;
        if (reserved_hit) begin
            tok_kind = tcl_pkg::KIND_RESERVED;
        end else if (all_digits_reg && dot_count_reg == 2'd0) begin
            tok_kind = tcl_pkg::KIND_INTEGER;
        end else if (operator_hit) begin
            tok_kind = tcl_pkg::KIND_OPERATOR;
        end else if (ident_ok_reg) begin
            tok_kind = tcl_pkg::KIND_VARIABLE;
        end else if (all_digits_reg && dot_count_reg == 2'd1 && len_reg != 8'd1) begin
            tok_kind = tcl_pkg::KIND_FLOAT;
        end else begin
            tok_bad = tok_has;
        end
    end

    // Character classes of the incoming byte.
    always_comb begin
        is_digit  = (char_code >= "0") && (char_code <= "9");
        is_letter = ((char_code >= "a") && (char_code <= "z")) ||
                    ((char_code >= "A") && (char_code <= "Z"));
        is_space  = (char_code == tcl_pkg::CHAR_SPACE) ||
                    ((char_code >= tcl_pkg::CHAR_TAB) && (char_code <= tcl_pkg::CHAR_CR));
        is_semi   = (char_code == tcl_pkg::CHAR_SEMI);
        is_dot    = (char_code == tcl_pkg::CHAR_DOT);
    end

    // Final verdict at end of input.
    always_comb begin
        err_after   = error_reg || tok_bad;
        ended_after = (tok_has && !error_reg) ? 1'b0 : ended_reg;
        final_kind  = (!err_after && ended_after) ? tcl_pkg::KIND_ACCEPT
                                                  : tcl_pkg::KIND_COMPILE_ERROR;
    end

    // Token state update and the results each item causes.
    always_comb begin
        prefix_next       = prefix_reg;
        len_next          = len_reg;
        all_digits_next   = all_digits_reg;
        ident_ok_next     = ident_ok_reg;
        dot_count_next    = dot_count_reg;
        error_next        = error_reg;
        ended_next        = ended_reg;
        push              = 1'b0;
        push_entry.pair   = 1'b0;
        push_entry.first  = tok_kind;
        push_entry.second = tcl_pkg::KIND_STMT_END;

        if (accept) begin
            if (end_of_input) begin
                push = 1'b1;
                if (!error_reg && tok_has && !tok_bad) begin
                    push_entry.pair   = 1'b1;
                    push_entry.first  = tok_kind;
                    push_entry.second = final_kind;
                end else begin
                    push_entry.first  = final_kind;
                end
                prefix_next     = '0;
                len_next        = 8'd0;
                all_digits_next = 1'b1;
                ident_ok_next   = 1'b1;
                dot_count_next  = 2'd0;
                error_next      = 1'b0;
                ended_next      = 1'b0;
            end else if (!error_reg) begin
                if (is_space || is_semi) begin
                    prefix_next     = '0;
                    len_next        = 8'd0;
                    all_digits_next = 1'b1;
                    ident_ok_next   = 1'b1;
                    dot_count_next  = 2'd0;
                    if (tok_bad) begin
                        error_next = 1'b1;
                    end else if (tok_has) begin
                        push             = 1'b1;
                        push_entry.pair  = is_semi;
                        push_entry.first = tok_kind;
                        ended_next       = is_semi;
                    end else if (is_semi) begin
                        push             = 1'b1;
                        push_entry.first = tcl_pkg::KIND_STMT_END;
                        ended_next       = 1'b1;
                    end
                end else begin
                    for (int i = 0; i < PREFIX_CHARS; i++) begin
                        if (len_reg == 8'(i)) begin
                            prefix_next[8*i +: 8] = char_code;
                        end
                    end
                    all_digits_next = all_digits_reg && (is_digit || is_dot);
                    if (is_dot && dot_count_reg != 2'd2) begin
                        dot_count_next = dot_count_reg + 2'd1;
                    end
                    ident_ok_next = ident_ok_reg &&
                                    (is_digit || is_letter ||
                                     char_code == tcl_pkg::CHAR_UNDER) &&
                                    !(len_reg == 8'd0 && is_digit);
                    if (len_reg != 8'hFF) begin
                        len_next = len_reg + 8'd1;
                    end
                end
            end
        end
    end

    // Token and verdict registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg     <= '0;
            len_reg        <= 8'd0;
            all_digits_reg <= 1'b1;
            ident_ok_reg   <= 1'b1;
            dot_count_reg  <= 2'd0;
            error_reg      <= 1'b0;
            ended_reg      <= 1'b0;
        end else begin
            prefix_reg     <= prefix_next;
            len_reg        <= len_next;
            all_digits_reg <= all_digits_next;
            ident_ok_reg   <= ident_ok_next;
            dot_count_reg  <= dot_count_next;
            error_reg      <= error_next;
            ended_reg      <= ended_next;
        end
    end

endmodule

/* src/tcl_queue.sv */
module tcl_queue #(
    parameter int DEPTH = tcl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tcl_pkg::entry_t  push_entry,
    input  logic             pop,
    output tcl_pkg::entry_t  head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcl_pkg::entry_t  store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign head    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update with wrap at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* src/tcl_back.sv */
module tcl_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  tcl_pkg::entry_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic           valid_reg, valid_next;
    tcl_pkg::kind_t kind_reg, kind_next;
    logic           last_reg, last_next;
    logic           second_reg, second_next;
    logic           load;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, kind_reg};
    assign m_tlast  = last_reg;
    assign load     = !valid_reg || m_tready;

    // Deliver the head entry one result at a time into the output register.
    always_comb begin
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        last_next   = last_reg;
        second_next = second_reg;
        pop         = 1'b0;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                if (second_reg) begin
                    kind_next   = head.second;
                    last_next   = 1'b1;
                    second_next = 1'b0;
                    pop         = 1'b1;
                end else begin
                    kind_next   = head.first;
                    last_next   = !head.pair;
                    second_next = head.pair;
                    pop         = !head.pair;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

endmodule

/* src/token_class_lexer.sv */
// An accepted item's results are written into the queue, then loaded one at a time into
// the output register, from which they are offered on the output.
// Throughput: one input item per cycle while the queue (four entries by default) has room;
// the output delivers one result per cycle while m_tready is high, so an item with two
// results holds it for both, and a steady run of such items slows the input once the queue fills.
// Reset: synchronous, active low; it clears the token state, the queue and the output
// valid at once, with no clearing pass.
module token_class_lexer #(
    parameter int PREFIX_CHARS = tcl_pkg::PREFIX_CHARS_DEFAULT,
    parameter int QUEUE_DEPTH  = tcl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tuser,   // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] kind, [7:3] zero
    output logic       m_tlast
);

    logic            accept;
    logic            push;
    tcl_pkg::entry_t push_entry;
    logic            pop;
    tcl_pkg::entry_t head;
    logic            empty;
    logic            full;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // Classifier: updates the token state and emits one queue entry per result group.
    tcl_front #(
        .PREFIX_CHARS (PREFIX_CHARS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .char_code    (s_tdata),
        .end_of_input (s_tuser),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Queue between classifier and output stage.
    tcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    // Output stage: splits entries into single result items.
    tcl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/tcl_checker.sv */
module tcl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled result item stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // Only the kind bits of the result carry information.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("result padding bits not zero");

    // The verdict at end of input is always the final result of its item.
    a_verdict_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == tcl_pkg::KIND_ACCEPT ||
                     m_tdata[2:0] == tcl_pkg::KIND_COMPILE_ERROR) |-> m_tlast)
        else $error("verdict result not marked last");

    // A statement end is always the final result of its item.
    a_stmt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == tcl_pkg::KIND_STMT_END |-> m_tlast)
        else $error("statement end not marked last");

endmodule

bind token_class_lexer tcl_checker u_tcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
